/* hw/rtl/ordered_insert_queue_unit_defines.svh */
// ----------------------------------------------------------------------------
// Ordered insert queue assertion macros
// Shorthand for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_INSERT_QUEUE_UNIT_DEFINES_SVH
`define ORDERED_INSERT_QUEUE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define OIQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define OIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/oiq_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered insert queue package
// Operation codes, field widths and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package oiq_pkg;

    // Transaction field widths
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = 16;
    localparam int RANK_W   = 8;
    localparam int OCC_W    = 5;

    // Input tdata layout, lowest field first
    localparam int IN_OP_LSB     = 0;
    localparam int IN_HANDLE_LSB = IN_OP_LSB + OP_W;
    localparam int IN_KEY_LSB    = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_RANK_LSB   = IN_KEY_LSB + KEY_W;
    localparam int IN_TDATA_W    = 48;

    localparam int OUT_TDATA_W   = 48;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_INS_KEY  = 2'd1,
        OP_INS_RANK = 2'd2,
        OP_POP      = 2'd3
    } oiq_op_t;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic cmp_en;   // register the compare against the incoming entry
        logic by_rank;  // compare on rank rather than key
        logic ins_en;   // shift towards the tail and place the new entry
        logic pop_en;   // shift towards the head
    } oiq_cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/oiq_cell.sv */
// ----------------------------------------------------------------------------
// Ordered insert queue cell
// One slot of the queue: holds an entry, compares it against the incoming
// entry and takes data from its left or right neighbour on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module oiq_cell #(
    parameter int KEY_BITS  = 16,
    parameter int RANK_BITS = 8
) (
    input  wire logic                            clk,
    input  wire oiq_pkg::oiq_cell_ctrl_t         ctrl,
    input  wire logic [KEY_BITS-1:0]             cmp_key,
    input  wire logic [RANK_BITS-1:0]            cmp_rank,
    input  wire logic [oiq_pkg::HANDLE_W-1:0]    new_handle,
    input  wire logic [KEY_BITS-1:0]             new_key,
    input  wire logic [RANK_BITS-1:0]            new_rank,
    input  wire logic                            ge_self,
    input  wire logic                            ge_left,
    input  wire logic [oiq_pkg::HANDLE_W-1:0]    left_handle,
    input  wire logic [KEY_BITS-1:0]             left_key,
    input  wire logic [RANK_BITS-1:0]            left_rank,
    input  wire logic [oiq_pkg::HANDLE_W-1:0]    right_handle,
    input  wire logic [KEY_BITS-1:0]             right_key,
    input  wire logic [RANK_BITS-1:0]            right_rank,
    output logic      [oiq_pkg::HANDLE_W-1:0]    handle,
    output logic      [KEY_BITS-1:0]             key,
    output logic      [RANK_BITS-1:0]            rank,
    output logic                                 match
);
    import oiq_pkg::*;

    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [RANK_BITS-1:0] rank_reg, rank_next;
    logic                 match_reg, match_next;

    // Compare on accept, shift on apply
    always_comb
    begin
        handle_next = handle_reg;
        key_next    = key_reg;
        rank_next   = rank_reg;
        match_next  = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = ctrl.by_rank ? (cmp_rank > rank_reg) : (cmp_key <= key_reg);
        end
        if (ctrl.ins_en && ge_self)
        begin
            // at or behind the insert point: new entry here, or the left one
            if (ge_left)
            begin
                handle_next = left_handle;
                key_next    = left_key;
                rank_next   = left_rank;
            end
            else
            begin
                handle_next = new_handle;
                key_next    = new_key;
                rank_next   = new_rank;
            end
        end
        else if (ctrl.pop_en)
        begin
            handle_next = right_handle;
            key_next    = right_key;
            rank_next   = right_rank;
        end
    end

    // Slot contents carry no reset
    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        key_reg    <= key_next;
        rank_reg   <= rank_next;
        match_reg  <= match_next;
    end

    assign handle = handle_reg;
    assign key    = key_reg;
    assign rank   = rank_reg;
    assign match  = match_reg;

endmodule

`default_nettype wire

/* hw/rtl/oiq_locate.sv */
// ----------------------------------------------------------------------------
// Ordered insert queue position finder
// Turns the per-cell compare bits into a mask of the cells at or behind the
// insert point, using a borrow chain to find the first match.
// ----------------------------------------------------------------------------
`default_nettype none

module oiq_locate #(
    parameter int DEPTH = 16
) (
    input  wire logic [DEPTH-1:0]            match,
    input  wire logic [$clog2(DEPTH+1)-1:0]  fill,
    input  wire logic                        append,
    output logic      [DEPTH-1:0]            ge
);
    import oiq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [DEPTH-1:0] occ;
    logic [DEPTH-1:0] tail;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] below;
    logic             tail_miss;

    // Occupied slots and the tail slot, as seen from the fill count
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_occ
        assign occ[i]  = fill > CNT_W'(i);
        assign tail[i] = fill == CNT_W'(i + 1);
    end

    // Tail fails the compare: entry goes behind the tail
    assign tail_miss = |(tail & ~match);

    // Ones strictly below the first occupied match
    assign hit   = match & occ;
    assign below = (hit - DEPTH'(1)) & ~hit;

    // A head match wins over a tail miss
    always_comb
    begin
        if (append || (tail_miss && !hit[0]) || (hit == '0))
        begin
            ge = ~occ;
        end
        else
        begin
            ge = ~below;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ordered_insert_queue_unit.sv */
// ----------------------------------------------------------------------------
// Ordered insert queue unit
// Bounded queue of handle/key/rank entries held in a chain of cells, with
// append, ordered insert by key or rank, and pop of the head.
//
//   Channel   Dir   Handshake            Content
//   s_*       in    s_tvalid/s_tready    op, item_handle, item_key, item_rank
//   m_*       out   m_tvalid/m_tready    popped entry, flags, occupancy
//
// An operation has an accept step and an apply step: every cell compares the
// incoming entry with its own in the accept cycle, and the apply cycle finds
// the insert point from the registered compare bits and shifts the whole chain at once.
// The apply cycle waits while the output register holds an untaken result.
// Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_insert_queue_unit_defines.svh"

module ordered_insert_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int RANK_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // op[1:0], item_handle[17:2], item_key[33:18], item_rank[41:34], zero pad
    input  wire logic [oiq_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_handle[15:0], out_key[31:16], out_rank[39:32], popped[40],
    // pop_empty[41], insert_rejected[42], occupancy[47:43]
    output logic      [oiq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import oiq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    oiq_op_t                op_reg;
    logic [HANDLE_W-1:0]    item_handle_reg;
    logic [KEY_BITS-1:0]    item_key_reg;
    logic [RANK_BITS-1:0]   item_rank_reg;

    oiq_op_t                in_op;
    logic [HANDLE_W-1:0]    in_handle;
    logic [KEY_BITS-1:0]    in_key;
    logic [RANK_BITS-1:0]   in_rank;

    logic                   accept;
    logic                   fire;
    logic                   full;
    logic                   empty;
    logic                   do_pop;
    logic                   do_ins;
    oiq_cell_ctrl_t         ctrl;

    logic [HANDLE_W-1:0]    cell_handle [DEPTH];
    logic [KEY_BITS-1:0]    cell_key    [DEPTH];
    logic [RANK_BITS-1:0]   cell_rank   [DEPTH];
    logic [HANDLE_W-1:0]    left_handle [DEPTH];
    logic [KEY_BITS-1:0]    left_key    [DEPTH];
    logic [RANK_BITS-1:0]   left_rank   [DEPTH];
    logic [HANDLE_W-1:0]    right_handle[DEPTH];
    logic [KEY_BITS-1:0]    right_key   [DEPTH];
    logic [RANK_BITS-1:0]   right_rank  [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH-1:0]       ge_vec;

    // Input field unpacking, key and rank cut to their stored width
    assign in_op     = oiq_op_t'(s_tdata[IN_HANDLE_LSB-1:IN_OP_LSB]);
    assign in_handle = s_tdata[IN_KEY_LSB-1:IN_HANDLE_LSB];
    assign in_key    = KEY_BITS'(s_tdata[IN_RANK_LSB-1:IN_KEY_LSB]);
    assign in_rank   = RANK_BITS'(s_tdata[IN_RANK_LSB+RANK_W-1:IN_RANK_LSB]);

    // Handshake and apply conditions
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == ST_APPLY) && (!m_tvalid_reg || m_tready);
    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_pop   = fire && (op_reg == OP_POP) && !empty;
    assign do_ins   = fire && (op_reg != OP_POP) && !full;

    assign ctrl.cmp_en  = accept;
    assign ctrl.by_rank = (in_op == OP_INS_RANK);
    assign ctrl.ins_en  = do_ins;
    assign ctrl.pop_en  = do_pop;

    // Incoming entry held for the apply cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= in_op;
            item_handle_reg <= in_handle;
            item_key_reg    <= in_key;
            item_rank_reg   <= in_rank;
        end
    end

    // Insert point
    oiq_locate #(
        .DEPTH (DEPTH)
    ) u_locate (
        .match  (match_vec),
        .fill   (fill_reg),
        .append (op_reg == OP_APPEND),
        .ge     (ge_vec)
    );

    // Chain of cells, slot 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_handle[i] = '0;
            assign left_key[i]    = '0;
            assign left_rank[i]   = '0;
        end
        else
        begin : g_mid_l
            assign left_handle[i] = cell_handle[i-1];
            assign left_key[i]    = cell_key[i-1];
            assign left_rank[i]   = cell_rank[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_handle[i] = '0;
            assign right_key[i]    = '0;
            assign right_rank[i]   = '0;
        end
        else
        begin : g_mid_r
            assign right_handle[i] = cell_handle[i+1];
            assign right_key[i]    = cell_key[i+1];
            assign right_rank[i]   = cell_rank[i+1];
        end

        oiq_cell #(
            .KEY_BITS  (KEY_BITS),
            .RANK_BITS (RANK_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .cmp_key      (in_key),
            .cmp_rank     (in_rank),
            .new_handle   (item_handle_reg),
            .new_key      (item_key_reg),
            .new_rank     (item_rank_reg),
            .ge_self      (ge_vec[i]),
            .ge_left      ((i == 0) ? 1'b0 : ge_vec[(i == 0) ? 0 : i - 1]),
            .left_handle  (left_handle[i]),
            .left_key     (left_key[i]),
            .left_rank    (left_rank[i]),
            .right_handle (right_handle[i]),
            .right_key    (right_key[i]),
            .right_rank   (right_rank[i]),
            .handle       (cell_handle[i]),
            .key          (cell_key[i]),
            .rank         (cell_rank[i]),
            .match        (match_vec[i])
        );
    end

    // Next state, fill count and result
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (fire)
                begin
                    if (do_pop)
                    begin
                        fill_next = fill_reg - CNT_W'(1);
                    end
                    else if (do_ins)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    m_tdata_next = {
                        OCC_W'(fill_next),
                        fire && (op_reg != OP_POP) && full,
                        fire && (op_reg == OP_POP) && empty,
                        do_pop,
                        do_pop ? RANK_W'(cell_rank[0]) : RANK_W'(0),
                        do_pop ? KEY_W'(cell_key[0]) : KEY_W'(0),
                        do_pop ? cell_handle[0] : HANDLE_W'(0)
                    };
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `OIQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    `OIQ_ASSERT_SAME(a_flags_excl, m_tvalid, $onehot0(m_tdata[OUT_TDATA_W-OCC_W-1:40]), "result flags overlap")
    `OIQ_ASSERT_NEXT(a_pop_count, do_pop, fill_reg == $past(fill_reg) - CNT_W'(1), "pop did not shrink queue")
    `OIQ_ASSERT_NEXT(a_reject_hold, fire && (op_reg != OP_POP) && full, fill_reg == CNT_W'(DEPTH), "rejected insert changed fill")

endmodule

`default_nettype wire

/* verif/tb_ordered_insert_queue_unit.sv */
// ----------------------------------------------------------------------------
// Ordered insert queue unit testbench
// Streams append, key insert, rank insert and pop transactions into the queue
// and checks every result against a behavioural copy of the queue kept here.
// The sender and receiver idle at random in phases, and the receiver holds
// off once for a long stretch so that the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_insert_queue_unit;

    import oiq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int RANDOM_OPS  = 1100;
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 30;
    localparam int MAX_PRINTS  = 60;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic [RANK_W-1:0]   rank;
    } entry_t;

    typedef struct packed {
        oiq_op_t op;
        entry_t  ent;
    } request_t;

    typedef struct packed {
        entry_t           ent;
        logic             popped;
        logic             pop_empty;
        logic             rejected;
        logic [OCC_W-1:0] occupancy;
    } outcome_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Stimulus backlog and outstanding expected results
    request_t op_backlog [$];
    outcome_t due_results [$];

    // Behavioural queue state
    entry_t slots [QDEPTH];
    int     fill;

    int  gen_level;
    int  total_requests;
    int  taken_count;
    int  result_count;
    int  error_count;
    int  pop_hits;
    int  pop_misses;
    int  reject_count;
    int  peak_fill;
    int  hold_left;
    bit  hold_done;
    bit  in_fire;

    ordered_insert_queue_unit #(
        .DEPTH     (QDEPTH),
        .KEY_BITS  (KEY_W),
        .RANK_BITS (RANK_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock and initial input levels
    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous watchdog
    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one transaction to the behavioural queue and return its outcome
    task automatic queue_model_step(input request_t rq, output outcome_t res);
        int  pos;
        int  i;
        bit  found;
        res       = '0;
        pos       = fill;
        found     = 1'b0;
        if (rq.op == OP_POP)
        begin
            if (fill == 0)
            begin
                res.pop_empty = 1'b1;
                pop_misses++;
            end
            else
            begin
                res.ent    = slots[0];
                res.popped = 1'b1;
                for (i = 1; i < fill; i++)
                    slots[i-1] = slots[i];
                fill--;
                pop_hits++;
            end
        end
        else if (fill >= QDEPTH)
        begin
            res.rejected = 1'b1;
            reject_count++;
        end
        else
        begin
            // Key insert: ahead of equal keys; rank insert: behind equal ranks
            if (rq.op == OP_INS_KEY)
            begin
                if (fill == 0 || rq.ent.key <= slots[0].key)
                    pos = 0;
                else if (rq.ent.key > slots[fill-1].key)
                    pos = fill;
                else
                    for (i = 1; i < fill && !found; i++)
                        if (rq.ent.key <= slots[i].key)
                        begin
                            pos   = i;
                            found = 1'b1;
                        end
            end
            else if (rq.op == OP_INS_RANK)
            begin
                if (fill == 0 || rq.ent.rank > slots[0].rank)
                    pos = 0;
                else if (rq.ent.rank <= slots[fill-1].rank)
                    pos = fill;
                else
                    for (i = 1; i < fill && !found; i++)
                        if (rq.ent.rank > slots[i].rank)
                        begin
                            pos   = i;
                            found = 1'b1;
                        end
            end
            for (i = fill; i > pos; i--)
                slots[i] = slots[i-1];
            slots[pos] = rq.ent;
            fill++;
            if (fill > peak_fill)
                peak_fill = fill;
        end
        res.occupancy = fill[OCC_W-1:0];
    endtask

    // Stimulus helpers; gen_level follows the expected fill level
    task automatic add_request(input oiq_op_t op, input logic [HANDLE_W-1:0] h,
                               input logic [KEY_W-1:0] k, input logic [RANK_W-1:0] r);
        request_t rq;
        rq.op         = op;
        rq.ent.handle = h;
        rq.ent.key    = k;
        rq.ent.rank   = r;
        op_backlog.push_back(rq);
        if (op == OP_POP)
        begin
            if (gen_level > 0)
                gen_level--;
        end
        else if (gen_level < QDEPTH)
            gen_level++;
    endtask

    // Keys and ranks are often drawn from a narrow range so that ties occur
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return KEY_W'($urandom_range(0, 7));
        else if (sel == 4)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return KEY_W'($urandom);
    endfunction

    function automatic logic [RANK_W-1:0] pick_rank();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return RANK_W'($urandom_range(0, 3));
        else if (sel == 4)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return RANK_W'($urandom);
    endfunction

    task automatic add_random_insert();
        add_request(oiq_op_t'($urandom_range(0, 2)), HANDLE_W'($urandom),
                    pick_key(), pick_rank());
    endtask

    task automatic add_random_pop();
        add_request(OP_POP, HANDLE_W'($urandom), KEY_W'($urandom), RANK_W'($urandom));
    endtask

    // Idle percentages per phase of the run
    function automatic int send_idle_pct();
        if (taken_count < total_requests / 3)
            return 38;
        else if (taken_count < (2 * total_requests) / 3)
            return 59;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (taken_count < total_requests / 3)
            return 59;
        else if (taken_count < (2 * total_requests) / 3)
            return 38;
        return 0;
    endfunction

    // Driver: record accepted transactions at the rising edge
    always @(posedge clk)
    begin
        request_t rq;
        outcome_t res;
        if (rst_n && s_tvalid && s_tready)
        begin
            rq.op         = oiq_op_t'(s_tdata[IN_OP_LSB +: OP_W]);
            rq.ent.handle = s_tdata[IN_HANDLE_LSB +: HANDLE_W];
            rq.ent.key    = s_tdata[IN_KEY_LSB +: KEY_W];
            rq.ent.rank   = s_tdata[IN_RANK_LSB +: RANK_W];
            queue_model_step(rq, res);
            due_results.push_back(res);
            taken_count++;
            in_fire <= 1'b1;
        end
        else
            in_fire <= 1'b0;
    end

    // Driver: present the next transaction at the falling edge
    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct())
            begin
                rq       = op_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(IN_TDATA_W-OP_W-HANDLE_W-KEY_W-RANK_W){1'b0}},
                             rq.ent.rank, rq.ent.key, rq.ent.handle, rq.op};
            end
            else
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= '0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && taken_count >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver ready, changed at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n || hold_left > 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ent.handle = m_tdata[15:0];
            got.ent.key    = m_tdata[31:16];
            got.ent.rank   = m_tdata[39:32];
            got.popped     = m_tdata[40];
            got.pop_empty  = m_tdata[41];
            got.rejected   = m_tdata[42];
            got.occupancy  = m_tdata[47:43];
            result_count++;
            if (due_results.size() == 0)
                report_mismatch($sformatf("unexpected result tdata=%h", m_tdata));
            else
            begin
                want = due_results.pop_front();
                if (got.ent.handle !== want.ent.handle)
                    report_mismatch($sformatf("result %0d out_handle %h, want %h",
                                    result_count, got.ent.handle, want.ent.handle));
                if (got.ent.key !== want.ent.key)
                    report_mismatch($sformatf("result %0d out_key %h, want %h",
                                    result_count, got.ent.key, want.ent.key));
                if (got.ent.rank !== want.ent.rank)
                    report_mismatch($sformatf("result %0d out_rank %h, want %h",
                                    result_count, got.ent.rank, want.ent.rank));
                if (got.popped !== want.popped)
                    report_mismatch($sformatf("result %0d popped %b, want %b",
                                    result_count, got.popped, want.popped));
                if (got.pop_empty !== want.pop_empty)
                    report_mismatch($sformatf("result %0d pop_empty %b, want %b",
                                    result_count, got.pop_empty, want.pop_empty));
                if (got.rejected !== want.rejected)
                    report_mismatch($sformatf("result %0d insert_rejected %b, want %b",
                                    result_count, got.rejected, want.rejected));
                if (got.occupancy !== want.occupancy)
                    report_mismatch($sformatf("result %0d occupancy %0d, want %0d",
                                    result_count, got.occupancy, want.occupancy));
            end
        end
    end

    // Build the stimulus, release reset and wait for the queue to settle
    initial
    begin
        int seg;
        int n;
        int i;
        fill         = 0;
        gen_level    = 0;
        taken_count  = 0;
        result_count = 0;
        error_count  = 0;
        pop_hits     = 0;
        pop_misses   = 0;
        reject_count = 0;
        peak_fill    = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        in_fire      = 1'b0;

        // Directed: empty pop, each placement rule, field extremes, full queue
        add_request(OP_POP,      16'h0000, 16'h0000, 8'h00);
        add_request(OP_INS_KEY,  16'hffff, 16'h1234, 8'h80);
        add_request(OP_INS_RANK, 16'h0001, 16'h2000, 8'h80);
        add_request(OP_INS_KEY,  16'h0002, 16'h1234, 8'h10);
        add_request(OP_INS_KEY,  16'h0003, 16'hffff, 8'h20);
        add_request(OP_INS_KEY,  16'h0004, 16'h1800, 8'h30);
        add_request(OP_INS_RANK, 16'h0005, 16'h0100, 8'hff);
        add_request(OP_INS_RANK, 16'h0006, 16'h0200, 8'h00);
        add_request(OP_INS_RANK, 16'h0007, 16'h0300, 8'h80);
        add_request(OP_APPEND,   16'h0000, 16'h0000, 8'h00);
        add_request(OP_APPEND,   16'hffff, 16'hffff, 8'hff);
        add_request(OP_INS_KEY,  16'haaaa, 16'h0000, 8'h55);
        for (i = 0; i < 4; i++)
            add_request(OP_APPEND, 16'h5555, 16'haaaa, 8'haa);
        add_request(OP_INS_KEY,  16'h0bad, 16'h0000, 8'hff);
        add_request(OP_INS_RANK, 16'h0bad, 16'hffff, 8'hff);
        add_request(OP_APPEND,   16'h0bad, 16'h0001, 8'h01);
        for (i = 0; i < 3; i++)
            add_random_pop();

        // Random: fill bursts, drain bursts and mixed stretches
        while (op_backlog.size() < RANDOM_OPS + 22)
        begin
            seg = $urandom_range(0, 3);
            if (seg == 0)
            begin
                n = $urandom_range(QDEPTH - 2, QDEPTH + 6);
                for (i = 0; i < n; i++)
                    add_random_insert();
            end
            else if (seg == 1)
            begin
                n = gen_level + $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    add_random_pop();
            end
            else
            begin
                n = $urandom_range(10, 30);
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 99) < 40)
                        add_random_pop();
                    else
                        add_random_insert();
            end
        end
        total_requests = op_backlog.size();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (taken_count < total_requests || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d transactions: %0d pops returned an entry, %0d found it empty,",
                 taken_count, pop_hits, pop_misses);
        $display("%0d inserts rejected when full, peak occupancy %0d, %0d mismatches.",
                 reject_count, peak_fill, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/oiq_pkg.sv
hw/rtl/oiq_cell.sv
hw/rtl/oiq_locate.sv
hw/rtl/ordered_insert_queue_unit.sv
verif/tb_ordered_insert_queue_unit.sv
